// ----- rtl/adcc_pkg.sv -----
// Shared types, constants and the thermistor coefficient table for the
// ADC channel conditioner. Used by the top level and its checker.
// No dependencies.
package adcc_pkg;

    localparam int NUM_CHANNELS_DEF = 7;

    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 12;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 16;
    localparam int TYPE_W     = 2;
    localparam int ADDR_W     = 5;
    localparam int APB_W      = 32;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 72;

    // Shared multiplier operands and the kept width of its product.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 48;
    localparam int SQ_W   = 2 * SAMPLE_W;

    // Serial divider: the dividend is sample times gain.
    localparam int DIVIDEND_W = SAMPLE_W + CFG_W;
    localparam int REM_W      = CFG_W + 1;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int STEP_W     = 5;

    localparam int FILT_K     = 110;
    localparam int FILT_SHIFT = 7;
    localparam int FIX_SHIFT  = 16;
    localparam int NO_SENSOR_TEMP = 234;

    // Channel codes.
    localparam logic [CH_W-1:0] CH_CURRENT  = 3'd0;
    localparam logic [CH_W-1:0] CH_SUPPLY   = 3'd1;
    localparam logic [CH_W-1:0] CH_INT_TEMP = 3'd2;
    localparam logic [CH_W-1:0] CH_PROBE1   = 3'd3;
    localparam logic [CH_W-1:0] CH_PROBE2   = 3'd4;
    localparam logic [CH_W-1:0] CH_BRAKE    = 3'd5;
    localparam logic [CH_W-1:0] CH_THROTTLE = 3'd6;
    localparam logic [CH_W-1:0] CH_UNUSED   = 3'd7;

    // Register indexes.
    localparam logic [2:0] REG_CURRENT_GAIN = 3'd0;
    localparam logic [2:0] REG_CURRENT_DIV  = 3'd1;
    localparam logic [2:0] REG_SUPPLY_GAIN  = 3'd2;
    localparam logic [2:0] REG_SUPPLY_DIV   = 3'd3;
    localparam logic [2:0] REG_PEDAL_GAIN   = 3'd4;
    localparam logic [2:0] REG_PEDAL_DIV    = 3'd5;
    localparam logic [2:0] REG_PROBE1_TYPE  = 3'd6;
    localparam logic [2:0] REG_PROBE2_TYPE  = 3'd7;

    // Sensor types.
    localparam logic [TYPE_W-1:0] SENSOR_NTC3380 = 2'd0;
    localparam logic [TYPE_W-1:0] SENSOR_NTC3950 = 2'd1;

    localparam logic [SAMPLE_W-1:0] NTC3380_HI = 12'd2500;
    localparam logic [SAMPLE_W-1:0] NTC3380_LO = 12'd1000;
    localparam logic [SAMPLE_W-1:0] NTC3950_HI = 12'd2300;
    localparam logic [SAMPLE_W-1:0] NTC3950_LO = 12'd750;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE_MUL,
        ST_DIV,
        ST_POLY,
        ST_FILT_MUL,
        ST_FILT_DIV,
        ST_FILT_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] c3;
        logic signed [VAL_W-1:0] c2;
        logic signed [VAL_W-1:0] c1;
        logic signed [VAL_W-1:0] c0;
    } coef_t;

    // Cubic coefficients for the segment that the sample falls in.
    function automatic coef_t ntc_coef(input logic [TYPE_W-1:0] kind,
                                       input logic [SAMPLE_W-1:0] raw);
        coef_t c;
        c = '0;
        case (kind)
            SENSOR_NTC3950:
            begin
                if (raw > NTC3950_HI)
                    c = {-32'sd17547019, 32'sd2118824, -32'sd99297, 32'sd119879668};
                else if (raw > NTC3950_LO)
                    c = {-32'sd11466230, 32'sd1100240, -32'sd49255, 32'sd69839119};
                else
                    c = {-32'sd369412926, 32'sd12457346, -32'sd171761, 32'sd99558307};
            end
            default:
            begin
                if (raw > NTC3380_HI)
                    c = {-32'sd14430708, 32'sd1696358, -32'sd82720, 32'sd106399799};
                else if (raw > NTC3380_LO)
                    c = {-32'sd12296842, 32'sd1209989, -32'sd56206, 32'sd78684933};
                else
                    c = {-32'sd223039414, 32'sd9322894, -32'sd162054, 32'sd109513152};
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/adc_channel_conditioner.sv -----
// ADC channel conditioner: scaling, NTC linearisation and per-channel low-pass.
// One shared multiplier and a serial divider run under a small sequencer.
// Depends on adcc_pkg.
//
// Usage: the slave stream takes one word per sample, channel in tdata[2:0] and
// the 12-bit sample in tdata[14:3]. The master stream returns one word per
// sample: channel, converted value and filtered value. Gains, divisors and
// probe sensor types sit on the APB port at byte addresses 0x00 to 0x1C. The
// user must see that they are written only while the block is idle; the block
// itself does not enforce it. From acceptance to a valid result, the current,
// supply and pedal channels pass the scaling multiply, the bit-serial divider
// and the filter; a thermistor channel makes multiplier passes for the cubic,
// then the filter; a probe with no sensor goes straight to the filter, and an
// unused channel code straight to the output. s_axis_tready is high only while
// the sequencer is idle, so a new sample can be taken in the cycle after the
// previous result has been loaded. The result waits in an output register;
// if the receiver stalls, the next sample is still accepted and processed,
// and the sequencer holds its result until the output register is free.
// Reset clears the filter store to zero, gains and divisors to one and the
// sensor types to NTC 3380.
module adc_channel_conditioner #(
    parameter int NUM_CHANNELS = adcc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [adcc_pkg::ADDR_W-1:0]     paddr,
    input  logic [adcc_pkg::APB_W-1:0]      pwdata,
    output logic [adcc_pkg::APB_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] channel, [14:3] raw_sample, [15] zero
    input  logic [adcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] channel_out, [34:3] converted_value, [66:35] filtered_value,
    // [71:67] zero
    output logic [adcc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PAD_W = adcc_pkg::OUT_DATA_W - adcc_pkg::CH_W - 2 * adcc_pkg::VAL_W;

    // Configuration registers.
    logic [adcc_pkg::CFG_W-1:0]  current_gain_reg, current_div_reg;
    logic [adcc_pkg::CFG_W-1:0]  supply_gain_reg, supply_div_reg;
    logic [adcc_pkg::CFG_W-1:0]  pedal_gain_reg, pedal_div_reg;
    logic [adcc_pkg::TYPE_W-1:0] probe1_type_reg, probe2_type_reg;
    logic                        cfg_we;

    // Sequencer and datapath.
    adcc_pkg::state_t state_reg, state_next;
    logic [adcc_pkg::STEP_W-1:0]     step_reg;
    logic [adcc_pkg::CH_W-1:0]       ch_reg;
    logic [adcc_pkg::SAMPLE_W-1:0]   raw_reg;
    logic [adcc_pkg::TYPE_W-1:0]     type_reg;
    logic                            store_en_reg;
    logic [adcc_pkg::SQ_W-1:0]       sq_reg;
    logic [adcc_pkg::PROD_W-1:0]     prod_reg;
    logic [adcc_pkg::VAL_W-1:0]      acc_reg;
    logic [adcc_pkg::VAL_W-1:0]      conv_reg;
    logic [adcc_pkg::DIVIDEND_W-1:0] quot_reg;
    logic [adcc_pkg::REM_W-1:0]      rem_reg;
    logic [adcc_pkg::VAL_W-1:0]      filt_store_reg [NUM_CHANNELS];

    logic                            m_valid_reg;
    logic [adcc_pkg::OUT_DATA_W-1:0] m_data_reg;

    // Input decode.
    logic [adcc_pkg::CH_W-1:0]     in_ch;
    logic [adcc_pkg::SAMPLE_W-1:0] in_raw;
    logic [adcc_pkg::TYPE_W-1:0]   in_type;
    logic                          in_valid_ch, in_is_temp, in_no_sensor, accept;

    // Shared multiplier.
    logic signed [adcc_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*adcc_pkg::MUL_W-1:0] mul_full;

    logic [adcc_pkg::CFG_W-1:0]      gain_sel, div_sel, div_eff;
    logic [adcc_pkg::REM_W-1:0]      rem_sh, rem_next;
    logic                            div_ge;
    logic [adcc_pkg::DIVIDEND_W-1:0] quot_next;
    adcc_pkg::coef_t                 coef;
    logic [adcc_pkg::VAL_W-1:0]      poly_sum, prev_val, filt_sum;
    logic [adcc_pkg::PROD_W-1:0]     filt_biased;
    logic [IDX_W-1:0]                ch_idx;
    logic                            out_load;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gain_reg <= adcc_pkg::CFG_W'(1);
            current_div_reg  <= adcc_pkg::CFG_W'(1);
            supply_gain_reg  <= adcc_pkg::CFG_W'(1);
            supply_div_reg   <= adcc_pkg::CFG_W'(1);
            pedal_gain_reg   <= adcc_pkg::CFG_W'(1);
            pedal_div_reg    <= adcc_pkg::CFG_W'(1);
            probe1_type_reg  <= adcc_pkg::SENSOR_NTC3380;
            probe2_type_reg  <= adcc_pkg::SENSOR_NTC3380;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                adcc_pkg::REG_CURRENT_GAIN: current_gain_reg <= pwdata[15:0];
                adcc_pkg::REG_CURRENT_DIV:  current_div_reg  <= pwdata[15:0];
                adcc_pkg::REG_SUPPLY_GAIN:  supply_gain_reg  <= pwdata[15:0];
                adcc_pkg::REG_SUPPLY_DIV:   supply_div_reg   <= pwdata[15:0];
                adcc_pkg::REG_PEDAL_GAIN:   pedal_gain_reg   <= pwdata[15:0];
                adcc_pkg::REG_PEDAL_DIV:    pedal_div_reg    <= pwdata[15:0];
                adcc_pkg::REG_PROBE1_TYPE:  probe1_type_reg  <= pwdata[1:0];
                adcc_pkg::REG_PROBE2_TYPE:  probe2_type_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            adcc_pkg::REG_CURRENT_GAIN: prdata = {16'd0, current_gain_reg};
            adcc_pkg::REG_CURRENT_DIV:  prdata = {16'd0, current_div_reg};
            adcc_pkg::REG_SUPPLY_GAIN:  prdata = {16'd0, supply_gain_reg};
            adcc_pkg::REG_SUPPLY_DIV:   prdata = {16'd0, supply_div_reg};
            adcc_pkg::REG_PEDAL_GAIN:   prdata = {16'd0, pedal_gain_reg};
            adcc_pkg::REG_PEDAL_DIV:    prdata = {16'd0, pedal_div_reg};
            adcc_pkg::REG_PROBE1_TYPE:  prdata = {30'd0, probe1_type_reg};
            adcc_pkg::REG_PROBE2_TYPE:  prdata = {30'd0, probe2_type_reg};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- input decode ----------------
    assign in_ch  = s_axis_tdata[2:0];
    assign in_raw = s_axis_tdata[14:3];
    assign accept = s_axis_tvalid && s_axis_tready;

    assign in_valid_ch = (in_ch != adcc_pkg::CH_UNUSED) && (int'(in_ch) < NUM_CHANNELS);
    assign in_is_temp  = (in_ch == adcc_pkg::CH_INT_TEMP) || (in_ch == adcc_pkg::CH_PROBE1)
                      || (in_ch == adcc_pkg::CH_PROBE2);

    always_comb
    begin
        case (in_ch)
            adcc_pkg::CH_PROBE1: in_type = probe1_type_reg;
            adcc_pkg::CH_PROBE2: in_type = probe2_type_reg;
            default:             in_type = adcc_pkg::SENSOR_NTC3380;
        endcase
    end

    assign in_no_sensor = (in_type != adcc_pkg::SENSOR_NTC3380)
                       && (in_type != adcc_pkg::SENSOR_NTC3950);

    // ---------------- gain and divisor selection ----------------
    always_comb
    begin
        case (ch_reg)
            adcc_pkg::CH_CURRENT:
            begin
                gain_sel = current_gain_reg;
                div_sel  = current_div_reg;
            end
            adcc_pkg::CH_SUPPLY:
            begin
                gain_sel = supply_gain_reg;
                div_sel  = supply_div_reg;
            end
            default:
            begin
                gain_sel = pedal_gain_reg;
                div_sel  = pedal_div_reg;
            end
        endcase
    end

    // A divisor of zero behaves as one.
    assign div_eff = (div_sel == '0) ? adcc_pkg::CFG_W'(1) : div_sel;

    // Restoring divider, one quotient bit per cycle.
    assign rem_sh    = {rem_reg[adcc_pkg::REM_W-2:0], quot_reg[adcc_pkg::DIVIDEND_W-1]};
    assign div_ge    = rem_sh >= {1'b0, div_eff};
    assign rem_next  = div_ge ? (rem_sh - {1'b0, div_eff}) : rem_sh;
    assign quot_next = {quot_reg[adcc_pkg::DIVIDEND_W-2:0], div_ge};

    // ---------------- cubic and filter helpers ----------------
    assign coef     = adcc_pkg::ntc_coef(type_reg, raw_reg);
    assign poly_sum = acc_reg + prod_reg[31:0];

    assign ch_idx   = IDX_W'({1'b0, ch_reg});
    assign prev_val = store_en_reg ? filt_store_reg[ch_idx] : '0;

    // Division by 128 truncating toward zero: bias negative products first.
    assign filt_biased = prod_reg + (prod_reg[adcc_pkg::PROD_W-1]
                       ? adcc_pkg::PROD_W'((1 << adcc_pkg::FILT_SHIFT) - 1)
                       : adcc_pkg::PROD_W'(0));
    assign filt_sum    = conv_reg + acc_reg;

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            adcc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_valid_ch)
                        state_next = adcc_pkg::ST_OUT;
                    else if (in_is_temp && in_no_sensor)
                        state_next = adcc_pkg::ST_FILT_MUL;
                    else if (in_is_temp)
                        state_next = adcc_pkg::ST_POLY;
                    else
                        state_next = adcc_pkg::ST_SCALE_MUL;
                end
            end
            adcc_pkg::ST_SCALE_MUL: state_next = adcc_pkg::ST_DIV;
            adcc_pkg::ST_DIV:
            begin
                if (step_reg == adcc_pkg::STEP_W'(adcc_pkg::DIV_STEPS - 1))
                    state_next = adcc_pkg::ST_FILT_MUL;
            end
            adcc_pkg::ST_POLY:
            begin
                if (step_reg == adcc_pkg::STEP_W'(5))
                    state_next = adcc_pkg::ST_FILT_MUL;
            end
            adcc_pkg::ST_FILT_MUL: state_next = adcc_pkg::ST_FILT_DIV;
            adcc_pkg::ST_FILT_DIV: state_next = adcc_pkg::ST_FILT_ADD;
            adcc_pkg::ST_FILT_ADD: state_next = adcc_pkg::ST_OUT;
            adcc_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = adcc_pkg::ST_IDLE;
            end
            default: state_next = adcc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            adcc_pkg::ST_IDLE: s_axis_tready = 1'b1;
            adcc_pkg::ST_SCALE_MUL:
            begin
                mul_a = {21'd0, raw_reg};
                mul_b = {17'd0, gain_sel};
            end
            adcc_pkg::ST_POLY:
            begin
                case (step_reg[2:0])
                    3'd0:
                    begin
                        mul_a = {21'd0, raw_reg};
                        mul_b = {21'd0, raw_reg};
                    end
                    3'd1:
                    begin
                        mul_a = {9'd0, prod_reg[23:0]};
                        mul_b = {21'd0, raw_reg};
                    end
                    3'd2:
                    begin
                        mul_a = {13'd0, prod_reg[35:16]};
                        mul_b = {coef.c3[31], coef.c3};
                    end
                    3'd3:
                    begin
                        mul_a = {9'd0, sq_reg};
                        mul_b = {coef.c2[31], coef.c2};
                    end
                    3'd4:
                    begin
                        mul_a = {21'd0, raw_reg};
                        mul_b = {coef.c1[31], coef.c1};
                    end
                    default: ;
                endcase
            end
            adcc_pkg::ST_FILT_MUL:
            begin
                mul_a = {prev_val[31], prev_val} - {conv_reg[31], conv_reg};
                mul_b = adcc_pkg::MUL_W'(adcc_pkg::FILT_K);
            end
            adcc_pkg::ST_OUT: out_load = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= adcc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[adcc_pkg::PROD_W-1:0];
        case (state_reg)
            adcc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ch_reg       <= in_ch;
                    raw_reg      <= in_raw;
                    type_reg     <= in_type;
                    store_en_reg <= in_valid_ch;
                    step_reg     <= '0;
                    acc_reg      <= '0;
                    conv_reg     <= (in_valid_ch && in_is_temp && in_no_sensor)
                                  ? adcc_pkg::VAL_W'(adcc_pkg::NO_SENSOR_TEMP) : '0;
                end
            end
            adcc_pkg::ST_SCALE_MUL:
            begin
                quot_reg <= mul_full[adcc_pkg::DIVIDEND_W-1:0];
                rem_reg  <= '0;
                step_reg <= '0;
            end
            adcc_pkg::ST_DIV:
            begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
                conv_reg <= adcc_pkg::VAL_W'(quot_next);
            end
            adcc_pkg::ST_POLY:
            begin
                step_reg <= step_reg + 1'b1;
                case (step_reg[2:0])
                    3'd1: sq_reg  <= prod_reg[23:0];
                    3'd3: acc_reg <= prod_reg[47:16] + coef.c0;
                    3'd4: acc_reg <= acc_reg + prod_reg[47:16];
                    3'd5: conv_reg <= {{16{poly_sum[31]}}, poly_sum[31:16]};
                    default: ;
                endcase
            end
            adcc_pkg::ST_FILT_DIV: acc_reg <= filt_biased[38:7];
            adcc_pkg::ST_FILT_ADD: acc_reg <= filt_sum;
            default: ;
        endcase
    end

    // Per-channel filter state, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                filt_store_reg[i] <= '0;
        end
        else if (state_reg == adcc_pkg::ST_FILT_ADD && store_en_reg)
        begin
            filt_store_reg[ch_idx] <= filt_sum;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_data_reg <= {{PAD_W{1'b0}}, acc_reg, conv_reg, ch_reg};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- rtl/adcc_checker.sv -----
// Port-level checks for the ADC channel conditioner, bound to the top level.
// Depends on adcc_pkg and adc_channel_conditioner.
module adcc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pready,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [adcc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // The sequencer is busy in the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in consecutive cycles");

    // An unused channel code returns zero values.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == adcc_pkg::CH_UNUSED)
        |-> (m_axis_tdata[66:3] == '0))
        else $error("unused channel returned non-zero values");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind adc_channel_conditioner adcc_checker u_adcc_checker (.*);

// ----- tb/adcc_result_checker.sv -----
// Result checker for the ADC channel conditioner: mirrors the register file
// from the APB writes, predicts each result word and compares it with the output.
// Depends on adcc_pkg.
module adcc_result_checker #(
    parameter int NUM_CHANNELS = adcc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [adcc_pkg::ADDR_W-1:0]     paddr,
    input  logic [adcc_pkg::APB_W-1:0]      pwdata,
    input  logic                            pready,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // [2:0] channel, [14:3] raw_sample, [15] zero
    input  logic [adcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] channel_out, [34:3] converted_value, [66:35] filtered_value,
    // [71:67] zero
    input  logic [adcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                              fail_count,
    output int                              results_seen,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import adcc_pkg::*;

    localparam longint FILT_DIV = 128;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CH_W-1:0]         ch;
        logic signed [VAL_W-1:0] converted;
        logic signed [VAL_W-1:0] filtered;
    } conditioned_t;

    logic [CFG_W-1:0]        gain_current;
    logic [CFG_W-1:0]        div_current;
    logic [CFG_W-1:0]        gain_supply;
    logic [CFG_W-1:0]        div_supply;
    logic [CFG_W-1:0]        gain_pedal;
    logic [CFG_W-1:0]        div_pedal;
    logic [TYPE_W-1:0]       probe1_kind;
    logic [TYPE_W-1:0]       probe2_kind;
    logic signed [VAL_W-1:0] lowpass_store [NUM_CHANNELS];

    conditioned_t pending_results [$];
    conditioned_t got;
    conditioned_t want;

    // The terms and their sum wrap to 32 bits; >>> on a longint rounds towards
    // minus infinity, as the fixed-point format requires.
    function automatic logic signed [VAL_W-1:0] ntc_cubic(input logic [SAMPLE_W-1:0] raw,
                                                         input longint c3, input longint c2,
                                                         input longint c1, input longint c0);
        longint      r;
        longint      sq;
        logic [31:0] t3;
        logic [31:0] t2;
        logic [31:0] t1;
        logic [31:0] acc;
        r   = raw;
        sq  = r * r;
        t3  = (((sq * r) >>> FIX_SHIFT) * c3) >>> FIX_SHIFT;
        t2  = (sq * c2) >>> FIX_SHIFT;
        t1  = r * c1;
        acc = t3 + t2 + t1 + c0[31:0];
        return $signed(acc) >>> FIX_SHIFT;
    endfunction

    function automatic logic signed [VAL_W-1:0] ntc_temperature(input logic [TYPE_W-1:0] kind,
                                                               input logic [SAMPLE_W-1:0] raw);
        logic signed [VAL_W-1:0] temp;
        case (kind)
            SENSOR_NTC3380:
            begin
                if (raw > NTC3380_HI)
                    temp = ntc_cubic(raw, -14430708, 1696358, -82720, 106399799);
                else if (raw > NTC3380_LO)
                    temp = ntc_cubic(raw, -12296842, 1209989, -56206, 78684933);
                else
                    temp = ntc_cubic(raw, -223039414, 9322894, -162054, 109513152);
            end
            SENSOR_NTC3950:
            begin
                if (raw > NTC3950_HI)
                    temp = ntc_cubic(raw, -17547019, 2118824, -99297, 119879668);
                else if (raw > NTC3950_LO)
                    temp = ntc_cubic(raw, -11466230, 1100240, -49255, 69839119);
                else
                    temp = ntc_cubic(raw, -369412926, 12457346, -171761, 99558307);
            end
            default:
                temp = NO_SENSOR_TEMP;
        endcase
        return temp;
    endfunction

    function automatic logic signed [VAL_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] raw,
                                                            input logic [CFG_W-1:0] gain,
                                                            input logic [CFG_W-1:0] divisor);
        logic [31:0] product;
        logic [31:0] d;
        product = raw * gain;
        d = (divisor == '0) ? 32'd1 : divisor;
        return product / d;
    endfunction

    // Converts one sample and advances that channel's low-pass filter.
    function automatic conditioned_t condition_sample(input logic [CH_W-1:0] ch,
                                                     input logic [SAMPLE_W-1:0] raw);
        conditioned_t            res;
        logic signed [VAL_W-1:0] conv;
        longint                  prev;
        longint                  diff;
        longint                  y;
        res.ch        = ch;
        res.converted = '0;
        res.filtered  = '0;
        case (ch)
            CH_CURRENT:  conv = scale_sample(raw, gain_current, div_current);
            CH_SUPPLY:   conv = scale_sample(raw, gain_supply, div_supply);
            CH_INT_TEMP: conv = ntc_temperature(SENSOR_NTC3380, raw);
            CH_PROBE1:   conv = ntc_temperature(probe1_kind, raw);
            CH_PROBE2:   conv = ntc_temperature(probe2_kind, raw);
            CH_BRAKE,
            CH_THROTTLE: conv = scale_sample(raw, gain_pedal, div_pedal);
            default:     conv = '0;
        endcase
        if (ch != CH_UNUSED && ch < NUM_CHANNELS)
        begin
            prev = lowpass_store[ch];
            diff = prev - conv;
            // Signed division truncates towards zero, unlike a shift.
            y = conv + (diff * FILT_K) / FILT_DIV;
            lowpass_store[ch] = y[31:0];
            res.converted = conv;
            res.filtered  = y[31:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_current <= 16'd1;
            div_current  <= 16'd1;
            gain_supply  <= 16'd1;
            div_supply   <= 16'd1;
            gain_pedal   <= 16'd1;
            div_pedal    <= 16'd1;
            probe1_kind  <= SENSOR_NTC3380;
            probe2_kind  <= SENSOR_NTC3380;
            for (int i = 0; i < NUM_CHANNELS; i++)
                lowpass_store[i] = '0;
            pending_results.delete();
            fail_count   <= 0;
            results_seen <= 0;
            outstanding  <= 0;
        end
        else
        begin
            // Retire an output word before queueing a new prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                got.ch        = m_axis_tdata[2:0];
                got.converted = m_axis_tdata[34:3];
                got.filtered  = m_axis_tdata[66:35];
                if (pending_results.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("mismatch: unpredicted word ch %0d conv %0d filt %0d",
                                 got.ch, got.converted, got.filtered);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.ch !== want.ch || got.converted !== want.converted ||
                        got.filtered !== want.filtered)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display("mismatch: got ch %0d conv %0d filt %0d, expected ch %0d conv %0d filt %0d",
                                     got.ch, got.converted, got.filtered,
                                     want.ch, want.converted, want.filtered);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(condition_sample(s_axis_tdata[2:0], s_axis_tdata[14:3]));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CURRENT_GAIN: gain_current <= pwdata[CFG_W-1:0];
                    REG_CURRENT_DIV:  div_current  <= pwdata[CFG_W-1:0];
                    REG_SUPPLY_GAIN:  gain_supply  <= pwdata[CFG_W-1:0];
                    REG_SUPPLY_DIV:   div_supply   <= pwdata[CFG_W-1:0];
                    REG_PEDAL_GAIN:   gain_pedal   <= pwdata[CFG_W-1:0];
                    REG_PEDAL_DIV:    div_pedal    <= pwdata[CFG_W-1:0];
                    REG_PROBE1_TYPE:  probe1_kind  <= pwdata[TYPE_W-1:0];
                    REG_PROBE2_TYPE:  probe2_kind  <= pwdata[TYPE_W-1:0];
                    default: ;
                endcase
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top of the ADC channel conditioner testbench: clock, reset, APB set-up and
// sample stimulus with random pacing; verdict from adcc_result_checker.
// Depends on adcc_pkg, adc_channel_conditioner and adcc_result_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adcc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 160;

    // Sensor type codes that select no thermistor.
    localparam logic [TYPE_W-1:0] SENSOR_NONE  = 2'd2;
    localparam logic [TYPE_W-1:0] SENSOR_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [APB_W-1:0]      pwdata = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int results_seen;
    int outstanding;
    int words_sent = 0;
    int burst_left = 0;
    int max_gap = 0;
    int stall_pct = 0;
    int stall_max = 0;
    int stall_left = 0;

    adc_channel_conditioner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    adcc_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .results_seen  (results_seen),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: errors");
        $finish;
    end

    // The receiver stalls for random stretches at a rate set per phase.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, stall_max);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Leaves psel high so that writes can follow back to back; the caller
    // releases the bus after the last one.
    task automatic apb_write(input logic [2:0] index, input logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] raw);
        if (max_gap > 0 && burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, raw, ch};
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Holds the sender until every word sent has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (results_seen != words_sent)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            1: v = NTC3380_LO - 1 + $urandom_range(0, 2);
            2: v = NTC3380_HI - 1 + $urandom_range(0, 2);
            3: v = NTC3950_LO - 1 + $urandom_range(0, 2);
            4: v = NTC3950_HI - 1 + $urandom_range(0, 2);
            default: v = $urandom_range(0, 4095);
        endcase
        return v;
    endfunction

    function automatic logic [CH_W-1:0] pick_channel();
        logic [CH_W-1:0] ch;
        if ($urandom_range(0, 15) == 0)
            ch = CH_UNUSED;
        else
            ch = $urandom_range(CH_CURRENT, CH_THROTTLE);
        return ch;
    endfunction

    // Gains and divisors, with zero, one and full scale favoured and the
    // unused upper bits sometimes set.
    function automatic logic [APB_W-1:0] pick_setting();
        logic [APB_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'd0;
            1: v = 32'd1;
            2: v = 32'h0000_FFFF;
            default: v = $urandom_range(0, 16'hFFFF);
        endcase
        if ($urandom_range(0, 3) == 0)
            v[31:16] = $urandom_range(0, 16'hFFFF);
        return v;
    endfunction

    function automatic logic [APB_W-1:0] pick_kind();
        logic [APB_W-1:0] v;
        v = $urandom_range(SENSOR_NTC3380, SENSOR_SPARE);
        if ($urandom_range(0, 3) == 0)
            v[31:TYPE_W] = $urandom();
        return v;
    endfunction

    task automatic write_settings(input bit every_reg);
        if (every_reg || $urandom_range(0, 1))
            apb_write(REG_CURRENT_GAIN, pick_setting());
        if (every_reg || $urandom_range(0, 1))
            apb_write(REG_CURRENT_DIV, pick_setting());
        if (every_reg || $urandom_range(0, 1))
            apb_write(REG_SUPPLY_GAIN, pick_setting());
        if (every_reg || $urandom_range(0, 1))
            apb_write(REG_SUPPLY_DIV, pick_setting());
        if (every_reg || $urandom_range(0, 1))
            apb_write(REG_PEDAL_GAIN, pick_setting());
        if (every_reg || $urandom_range(0, 1))
            apb_write(REG_PEDAL_DIV, pick_setting());
        if (every_reg || $urandom_range(0, 1))
            apb_write(REG_PROBE1_TYPE, pick_kind());
        if (every_reg || $urandom_range(0, 1))
            apb_write(REG_PROBE2_TYPE, pick_kind());
        apb_release();
    endtask

    task automatic set_pace(input int mode);
        burst_left = 0;
        case (mode)
            0:
            begin
                max_gap = 0;
                stall_pct <= 0;
                stall_max <= 0;
            end
            1:
            begin
                max_gap = 4;
                stall_pct <= 20;
                stall_max <= 3;
            end
            2:
            begin
                max_gap = 0;
                stall_pct <= 60;
                stall_max <= 20;
            end
            default:
            begin
                max_gap = 20;
                stall_pct <= 10;
                stall_max <= 8;
            end
        endcase
    endtask

    initial
    begin
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        set_pace(1);

        // Reset settings: unit scaling, both probes on the 3380 curve.
        send_word(CH_CURRENT, 12'd0);
        send_word(CH_CURRENT, 12'd4095);
        send_word(CH_SUPPLY, 12'd4095);
        send_word(CH_INT_TEMP, 12'd0);
        send_word(CH_INT_TEMP, NTC3380_LO);
        send_word(CH_INT_TEMP, NTC3380_LO + 12'd1);
        send_word(CH_INT_TEMP, NTC3380_HI);
        send_word(CH_INT_TEMP, NTC3380_HI + 12'd1);
        send_word(CH_INT_TEMP, 12'd4095);
        send_word(CH_BRAKE, 12'd4095);
        send_word(CH_THROTTLE, 12'd1234);
        send_word(CH_UNUSED, 12'd4095);
        send_word(CH_UNUSED, 12'd0);
        wait_idle();

        // Full-scale gains, a zero divisor, the 3950 curve and a spare type code.
        apb_write(REG_CURRENT_GAIN, 32'h0000_FFFF);
        apb_write(REG_CURRENT_DIV, 32'd0);
        apb_write(REG_SUPPLY_GAIN, 32'h0000_FFFF);
        apb_write(REG_SUPPLY_DIV, 32'd1);
        apb_write(REG_PEDAL_GAIN, 32'h0000_FFFF);
        apb_write(REG_PEDAL_DIV, 32'h0000_FFFF);
        apb_write(REG_PROBE1_TYPE, SENSOR_NTC3950);
        apb_write(REG_PROBE2_TYPE, SENSOR_SPARE);
        apb_release();
        send_word(CH_PROBE1, 12'd0);
        send_word(CH_PROBE1, NTC3950_LO);
        send_word(CH_PROBE1, NTC3950_LO + 12'd1);
        send_word(CH_PROBE1, NTC3950_HI);
        send_word(CH_PROBE1, NTC3950_HI + 12'd1);
        send_word(CH_PROBE1, 12'd4095);
        send_word(CH_PROBE2, 12'd100);
        send_word(CH_CURRENT, 12'd4095);
        send_word(CH_SUPPLY, 12'd4095);
        send_word(CH_BRAKE, 12'd4095);
        send_word(CH_THROTTLE, 12'd4094);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            write_settings(p == 0);
            if (p == 1)
            begin
                apb_write(REG_PROBE2_TYPE, SENSOR_NONE);
                apb_release();
            end
            set_pace(p % 4);
            n = 0;
            while (n < PHASE_WORDS)
            begin
                // Mostly whole frames of seven channels in order, the rest loose words.
                if ($urandom_range(0, 1))
                begin
                    for (int c = 0; c < NUM_CHANNELS_DEF; c++)
                        send_word(c, pick_sample());
                    n += NUM_CHANNELS_DEF;
                end
                else
                begin
                    send_word(pick_channel(), pick_sample());
                    n++;
                end
                if ($urandom_range(0, 149) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/adcc_pkg.sv
rtl/adc_channel_conditioner.sv
rtl/adcc_checker.sv
tb/adcc_result_checker.sv
tb/tb.sv
